// File: src/fccl_pkg.sv
// Package: shared types and constants for the friction circle curvature limit block
`default_nettype none
package fccl_pkg;
    localparam int unsigned GRAVITY_Q16 = 642253;
    localparam int unsigned RAD_W = 52;
    localparam int unsigned ROOT_W = 26;
    localparam int unsigned SQRT_STEPS = 26;
    localparam int unsigned K_NUM_W = 42;
    localparam int unsigned K_DEN_W = 32;
    localparam int unsigned K_Q_W = 42;
    localparam int unsigned R_NUM_W = 30;
    localparam int unsigned R_DEN_W = 16;
    localparam int unsigned R_Q_W = 30;
    localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;
    localparam logic [0:0] REG_FRICTION = 1'b0;
    localparam logic [0:0] REG_RATE_LIMIT = 1'b1;

    typedef struct packed {
        logic        zero_speed;
        logic        grip_exceeded;
        logic [15:0] speed;
        logic [15:0] rate_limit;
    } fccl_side_t;
endpackage
`default_nettype wire

// File: src/friction_circle_curvature_limit.sv
// Top level: friction circle curvature and curvature rate limits, fully pipelined
// Pipeline: 3 front stages + 26 root cells + 42 divider cells + 1 output register.
// Throughput: one transaction per cycle; the whole pipe advances unless the
// output register holds a result that the receiver is not taking.
// Each root cell resolves one root bit, each divider cell one quotient bit.
// Reset (rst_n low, async) clears all valid bits and loads the register defaults.
`default_nettype none
module friction_circle_curvature_limit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // speed[15:0], accel[31:16]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // max_curvature[31:0], max_curvature_rate[63:32]
    output logic [1:0]       m_tuser    // zero_speed[0], grip_exceeded[1]
);
    import fccl_pkg::*;

    logic [15:0] mu_reg;
    logic [15:0] rate_reg;
    logic        en;

    // Config writes; the user must write only while idle, the block itself does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_reg   <= 16'd16384;
            rate_reg <= 16'd410;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRICTION:   mu_reg   <= cfg_wdata;
                REG_RATE_LIMIT: rate_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipe stalls only when the output holds a result nobody takes.
    assign en = !m_tvalid || m_tready;
    assign s_tready = en;

    // Stage 1: mu*g product, accel magnitude.
    logic        v1_reg;
    logic [36:0] mug_prod_reg;
    logic [15:0] amag1_reg;
    logic [15:0] spd1_reg;
    logic [15:0] rl1_reg;
    logic [16:0] amag_next;
    always_comb
    begin
        amag_next = s_tdata[31] ? 17'h10000 - {1'b0, s_tdata[31:16]} : {1'b0, s_tdata[31:16]};
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= s_tvalid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mug_prod_reg <= 37'(mu_reg) * 37'(GRAVITY_Q16) + 37'd512;
            amag1_reg    <= amag_next[15:0];
            spd1_reg     <= s_tdata[15:0];
            rl1_reg      <= rate_reg;
        end
    end

    // Stage 2: squares (mu*g in Q20 fits 27 bits, a<<10 26 bits).
    logic        v2_reg;
    logic [53:0] mug_sq_reg;
    logic [51:0] a_sq_reg;
    logic [31:0] spd_sq_reg;
    logic [15:0] spd2_reg;
    logic [15:0] rl2_reg;
    logic [26:0] mug;
    logic [25:0] a_q20;
    always_comb
    begin
        mug   = mug_prod_reg[36:10];
        a_q20 = {amag1_reg, 10'd0};
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mug_sq_reg <= 54'(mug) * 54'(mug);
            a_sq_reg   <= 52'(a_q20) * 52'(a_q20);
            spd_sq_reg <= 32'(spd1_reg) * 32'(spd1_reg);
            spd2_reg   <= spd1_reg;
            rl2_reg    <= rl1_reg;
        end
    end

    // Stage 3: radicand with clamp. Real radicand < 2^52 since mu*g < 2^26.
    logic        v3_reg;
    logic [RAD_W-1:0] rad_reg;
    fccl_side_t  side3_reg;
    logic [31:0] spd_sq3_reg;
    logic        grip;
    logic [53:0] diff;
    always_comb
    begin
        grip = {2'b00, a_sq_reg} > mug_sq_reg;
        diff = mug_sq_reg - {2'b00, a_sq_reg};
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg     <= grip ? '0 : diff[RAD_W-1:0];
            spd_sq3_reg <= spd_sq_reg;
            side3_reg   <= '{zero_speed: spd2_reg == 16'd0, grip_exceeded: grip,
                             speed: spd2_reg, rate_limit: rl2_reg};
        end
    end

    // Root chain; the squared speed rides along in a parallel shift line.
    logic             sv [SQRT_STEPS+1];
    logic [RAD_W-1:0] srad [SQRT_STEPS+1];
    logic [ROOT_W+1:0] srem [SQRT_STEPS+1];
    logic [ROOT_W-1:0] sroot [SQRT_STEPS+1];
    fccl_side_t        sside [SQRT_STEPS+1];
    logic [31:0]       ssq [SQRT_STEPS];
    assign sv[0]    = v3_reg;
    assign srad[0]  = rad_reg;
    assign srem[0]  = '0;
    assign sroot[0] = '0;
    assign sside[0] = side3_reg;
    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_sqrt
        fccl_sqrt_cell u_cell
        (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(sv[i]), .in_rad(srad[i]), .in_rem(srem[i]),
            .in_root(sroot[i]), .in_side(sside[i]),
            .out_valid(sv[i+1]), .out_rad(srad[i+1]), .out_rem(srem[i+1]),
            .out_root(sroot[i+1]), .out_side(sside[i+1])
        );
        if (i == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (en)
                    ssq[0] <= spd_sq3_reg;
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk)
            begin
                if (en)
                    ssq[i] <= ssq[i-1];
            end
        end
    end

    // Divider chain: 42 steps for ay<<16 / v^2; the rate quotient joins for its last 30.
    logic               dv [K_Q_W+1];
    logic [K_NUM_W-1:0] dkn [K_Q_W+1];
    logic [K_DEN_W:0]   dkr [K_Q_W+1];
    logic [K_DEN_W-1:0] dkd [K_Q_W+1];
    logic [K_Q_W-1:0]   dkq [K_Q_W+1];
    logic [R_NUM_W-1:0] drn [K_Q_W+1];
    logic [R_DEN_W:0]   drr [K_Q_W+1];
    logic [R_Q_W-1:0]   drq [K_Q_W+1];
    fccl_side_t         dside [K_Q_W+1];
    assign dv[0]    = sv[SQRT_STEPS];
    assign dkn[0]   = {sroot[SQRT_STEPS], 16'd0};
    assign dkr[0]   = '0;
    assign dkd[0]   = ssq[SQRT_STEPS-1];
    assign dkq[0]   = '0;
    assign drn[0]   = {sside[SQRT_STEPS].rate_limit, 14'd0};
    assign drr[0]   = '0;
    assign drq[0]   = '0;
    assign dside[0] = sside[SQRT_STEPS];
    for (genvar j = 0; j < K_Q_W; j++)
    begin : g_div
        fccl_div_cell u_cell
        (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(dv[j]), .in_kn(dkn[j]), .in_kr(dkr[j]), .in_kd(dkd[j]),
            .in_kq(dkq[j]), .in_rn(drn[j]), .in_rr(drr[j]), .in_rq(drq[j]),
            .r_active(j >= K_Q_W - R_Q_W), .in_side(dside[j]),
            .out_valid(dv[j+1]), .out_kn(dkn[j+1]), .out_kr(dkr[j+1]),
            .out_kd(dkd[j+1]), .out_kq(dkq[j+1]), .out_rn(drn[j+1]),
            .out_rr(drr[j+1]), .out_rq(drq[j+1]), .out_side(dside[j+1])
        );
    end

    // Output register with saturation.
    fccl_side_t       fs;
    logic [K_Q_W-1:0] fkq;
    logic [R_Q_W-1:0] frq;
    logic [31:0]      kmax;
    logic [31:0]      kpmax;
    always_comb
    begin
        fs    = dside[K_Q_W];
        fkq   = dkq[K_Q_W];
        frq   = drq[K_Q_W];
        kmax  = (fs.zero_speed || fkq[K_Q_W-1:32] != '0) ? ALL_ONES32 : fkq[31:0];
        kpmax = fs.zero_speed ? ALL_ONES32 : 32'(frq);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid <= 1'b0;
        else if (en)
            m_tvalid <= dv[K_Q_W];
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata <= {kpmax, kmax};
            m_tuser <= {fs.grip_exceeded, fs.zero_speed};
        end
    end

    // A zero-speed result always carries both limits at all ones.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == {ALL_ONES32, ALL_ONES32})
        else $error("zero speed result not saturated");
    // A stalled output holds its result.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");
    // Grip loss at nonzero speed gives zero curvature.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] && !m_tuser[0] |-> m_tdata[31:0] == 32'd0)
        else $error("grip exceeded but curvature nonzero");
endmodule
`default_nettype wire

// File: src/fccl_sqrt_cell.sv
// One restoring square root step: consumes two radicand bits, emits one root bit
`default_nettype none
module fccl_sqrt_cell
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic [fccl_pkg::RAD_W-1:0]   in_rad,
    input  wire logic [fccl_pkg::ROOT_W+1:0]  in_rem,
    input  wire logic [fccl_pkg::ROOT_W-1:0]  in_root,
    input  wire fccl_pkg::fccl_side_t         in_side,
    output logic                              out_valid,
    output logic [fccl_pkg::RAD_W-1:0]        out_rad,
    output logic [fccl_pkg::ROOT_W+1:0]       out_rem,
    output logic [fccl_pkg::ROOT_W-1:0]       out_root,
    output fccl_pkg::fccl_side_t              out_side,
    input  wire logic                         en
);
    import fccl_pkg::*;
    logic [ROOT_W+1:0] trial;
    logic [ROOT_W+1:0] sub;
    logic              fits;
    always_comb
    begin
        trial = {in_rem[ROOT_W-1:0], in_rad[RAD_W-1 -: 2]};
        sub   = {in_root, 2'b01};
        fits  = trial >= sub;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (en)
            out_valid <= in_valid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_rad  <= {in_rad[RAD_W-3:0], 2'b00};
            out_rem  <= fits ? trial - sub : trial;
            out_root <= {in_root[ROOT_W-2:0], fits};
            out_side <= in_side;
        end
    end
endmodule
`default_nettype wire

// File: src/fccl_div_cell.sv
// One restoring division step: one curvature quotient bit per cell, and one rate quotient bit when r_active
`default_nettype none
module fccl_div_cell
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [fccl_pkg::K_NUM_W-1:0]  in_kn,
    input  wire logic [fccl_pkg::K_DEN_W:0]    in_kr,
    input  wire logic [fccl_pkg::K_DEN_W-1:0]  in_kd,
    input  wire logic [fccl_pkg::K_Q_W-1:0]    in_kq,
    input  wire logic [fccl_pkg::R_NUM_W-1:0]  in_rn,
    input  wire logic [fccl_pkg::R_DEN_W:0]    in_rr,
    input  wire logic [fccl_pkg::R_Q_W-1:0]    in_rq,
    input  wire logic                          r_active,
    input  wire fccl_pkg::fccl_side_t          in_side,
    output logic                               out_valid,
    output logic [fccl_pkg::K_NUM_W-1:0]       out_kn,
    output logic [fccl_pkg::K_DEN_W:0]         out_kr,
    output logic [fccl_pkg::K_DEN_W-1:0]       out_kd,
    output logic [fccl_pkg::K_Q_W-1:0]         out_kq,
    output logic [fccl_pkg::R_NUM_W-1:0]       out_rn,
    output logic [fccl_pkg::R_DEN_W:0]         out_rr,
    output logic [fccl_pkg::R_Q_W-1:0]         out_rq,
    output fccl_pkg::fccl_side_t               out_side
);
    import fccl_pkg::*;
    logic [K_DEN_W+1:0] kt;
    logic               kf;
    logic [R_DEN_W+1:0] rt;
    logic               rf;
    always_comb
    begin
        kt = {in_kr, in_kn[K_NUM_W-1]};
        kf = kt >= {2'b00, in_kd};
        rt = {in_rr, in_rn[R_NUM_W-1]};
        rf = rt >= {2'b00, in_side.speed};
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (en)
            out_valid <= in_valid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_kn   <= {in_kn[K_NUM_W-2:0], 1'b0};
            out_kr   <= kf ? (K_DEN_W+1)'(kt - {2'b00, in_kd}) : kt[K_DEN_W:0];
            out_kd   <= in_kd;
            out_kq   <= {in_kq[K_Q_W-2:0], kf};
            out_side <= in_side;
            if (r_active)
            begin
                out_rn <= {in_rn[R_NUM_W-2:0], 1'b0};
                out_rr <= rf ? (R_DEN_W+1)'(rt - {2'b00, in_side.speed}) : rt[R_DEN_W:0];
                out_rq <= {in_rq[R_Q_W-2:0], rf};
            end
            else
            begin
                out_rn <= in_rn;
                out_rr <= in_rr;
                out_rq <= in_rq;
            end
        end
    end
endmodule
`default_nettype wire

// File: tb/sv/fccl_checker.sv
// Checker: predicts friction circle limits from accepted inputs and compares outputs
`timescale 1ns / 1ps
module fccl_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [63:0] m_tdata,
    input  wire logic [1:0]  m_tuser,
    output int               fail_count,
    output int               pending
);
    import fccl_pkg::*;

    typedef struct packed {
        logic [31:0] curv;
        logic [31:0] curv_rate;
        logic        zero_speed;
        logic        grip;
    } limits_t;

    limits_t     limits_q[$];
    logic [15:0] mu_q14;
    logic [15:0] rate_q12;

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= root + bitv)
            begin
                x = x - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic limits_t friction_limits(input logic [15:0] speed,
                                                input logic [15:0] accel);
        limits_t     r;
        logic [63:0] mag;
        logic [63:0] mug;
        logic [63:0] mug_sq;
        logic [63:0] a_sq;
        logic [63:0] ay;
        logic [63:0] quo;
        mag = accel[15] ? 64'h10000 - {48'd0, accel} : {48'd0, accel};
        mug = ({48'd0, mu_q14} * 64'(GRAVITY_Q16) + 64'd512) >> 10;
        mug_sq = mug * mug;
        a_sq = (mag << 10) * (mag << 10);
        r.grip = a_sq > mug_sq;
        ay = int_sqrt(r.grip ? 64'd0 : mug_sq - a_sq);
        r.zero_speed = speed == 0;
        if (speed == 0)
        begin
            r.curv = ALL_ONES32;
            r.curv_rate = ALL_ONES32;
        end
        else
        begin
            quo = (ay << 16) / ({48'd0, speed} * {48'd0, speed});
            r.curv = quo > 64'hFFFF_FFFF ? ALL_ONES32 : quo[31:0];
            quo = ({48'd0, rate_q12} << 14) / {48'd0, speed};
            r.curv_rate = quo > 64'hFFFF_FFFF ? ALL_ONES32 : quo[31:0];
        end
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s at %0t: got %h expected %h", what, $realtime, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        limits_t w;
        if (!rst_n)
        begin
            mu_q14 <= 16'd16384;
            rate_q12 <= 16'd410;
            limits_q.delete();
            fail_count <= 0;
            pending = 0;
        end
        else
        begin
            // prediction uses the settings as of this edge; writes only happen when idle
            if (s_tvalid && s_tready)
                limits_q.push_back(friction_limits(s_tdata[15:0], s_tdata[31:16]));
            if (m_tvalid && m_tready)
            begin
                if (limits_q.size() == 0)
                    report("unexpected transaction", m_tdata[31:0], 32'd0);
                else
                begin
                    w = limits_q.pop_front();
                    if (m_tdata[31:0] !== w.curv)
                        report("max_curvature", m_tdata[31:0], w.curv);
                    if (m_tdata[63:32] !== w.curv_rate)
                        report("max_curvature_rate", m_tdata[63:32], w.curv_rate);
                    if (m_tuser[0] !== w.zero_speed)
                        report("zero_speed", {31'd0, m_tuser[0]}, {31'd0, w.zero_speed});
                    if (m_tuser[1] !== w.grip)
                        report("grip_exceeded", {31'd0, m_tuser[1]}, {31'd0, w.grip});
                end
            end
            pending = limits_q.size();
            if (cfg_we)
            begin
                if (cfg_index == REG_FRICTION)
                    mu_q14 <= cfg_wdata;
                else
                    rate_q12 <= cfg_wdata;
            end
        end
    end
endmodule

// File: tb/sv/testbench.sv
// Testbench top: stimulus, idling phases and verdict for the curvature limit block
`timescale 1ns / 1ps
module testbench;
    import fccl_pkg::*;

    localparam int LATENCY = 72;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [0:0]  cfg_index = REG_FRICTION;
    logic [15:0] cfg_wdata = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = 0;   // speed[15:0], accel[31:16]
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [63:0] m_tdata;       // max_curvature[31:0], max_curvature_rate[63:32]
    logic [1:0]  m_tuser;       // zero_speed[0], grip_exceeded[1]
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;   // sender gap chance, percent
    int          recv_stall_pct = 0;  // receiver stall chance, percent
    bit          hold_off = 0;        // long receiver stall request
    int          cycles = 0;

    always #5 clk = ~clk;

    friction_circle_curvature_limit u_dut (.*);

    fccl_checker u_chk (.*);

    // receiver: random stalls, or a long counted hold-off when asked
    always @(posedge clk)
    begin
        if (hold_off)
            m_tready <= 0;
        else
            m_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // run guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // offer one point, with random idle gaps before it; returns once accepted
    // and leaves tvalid high so the next point can follow without a gap
    task automatic send_point(input logic [15:0] speed, input logic [15:0] accel);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {accel, speed};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // wait until every prediction is matched, then let the pipe drain fully
    task automatic drain();
        s_tvalid <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
    endtask

    // random point: mostly realistic speeds and accels near the grip limit
    task automatic random_point();
        logic [15:0] sp;
        logic [15:0] ac;
        case ($urandom_range(5))
            0: sp = 16'($urandom_range(65535));
            1: sp = 16'($urandom_range(64));
            2: sp = 0;
            default: sp = 16'($urandom_range(40000, 100));
        endcase
        case ($urandom_range(3))
            0: ac = 16'($urandom_range(65535));
            default: ac = 16'(int'($urandom_range(12000)) * ($urandom_range(1) ? 1 : -1));
        endcase
        send_point(sp, ac);
    endtask

    initial
    begin
        logic [15:0] mu_set[5];
        logic [15:0] rate_set[5];
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, zero speed, grip exceeded, overflowing quotients
        send_point(16'd0, 16'd0);
        send_point(16'd0, 16'h7FFF);
        send_point(16'd1, 16'd0);
        send_point(16'd1, 16'h8000);
        send_point(16'hFFFF, 16'd0);
        send_point(16'hFFFF, 16'h7FFF);
        send_point(16'd1024, 16'd10035);   // just below mu*g
        send_point(16'd1024, 16'd10036);   // just above mu*g
        send_point(16'd1024, -16'sd10036);
        send_point(16'd3, 16'd5000);
        send_point(16'h8000, 16'h8001);
        send_point(16'h5555, 16'h5555);
        send_point(16'hAAAA, 16'hAAAA);
        drain();

        mu_set = '{16'd0, 16'hFFFF, 16'd14000, 16'd1, 16'd8192};
        rate_set = '{16'hFFFF, 16'd0, 16'd4096, 16'd1, 16'd410};
        for (int ph = 0; ph < 5; ph++)
        begin
            write_reg(REG_FRICTION, mu_set[ph]);
            write_reg(REG_RATE_LIMIT, rate_set[ph]);
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                3: begin send_idle_pct = 37; recv_stall_pct = 37; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (ph == 4)
            begin
                // long output hold-off while inputs keep coming: pipe fills, s_tready drops
                fork
                    begin
                        hold_off = 1;
                        repeat (300) @(posedge clk);
                        hold_off = 0;
                    end
                    repeat (100) random_point();
                join
                // sender pauses until every result has arrived
                s_tvalid <= 0;
                while (pending != 0)
                    @(posedge clk);
                repeat (70) random_point();
            end
            else
                repeat (170) random_point();
            drain();
        end

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
